/* hw/rtl/nsst_pkg.sv */
`default_nettype none

package nsst_pkg;

  // sample clock of the tone generator, in Hz
  localparam int unsigned SAMPLE_RATE = 15625;
  localparam int unsigned SR_W        = 14;   // bits of SAMPLE_RATE
  // half of the PWM top value: sawtooth amplitude
  localparam int unsigned PWM_HALF    = 127;
  localparam int unsigned HALF_W      = 7;    // bits of PWM_HALF

  localparam int unsigned MAX_NOTES   = 256;
  localparam int unsigned NOTE_W      = 8;
  localparam int unsigned FREQ_W      = 16;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned CNT_W       = 24;
  localparam int unsigned QT_W        = 16;
  localparam int unsigned SONG_W      = 9;
  localparam int unsigned STEP_CNT_W  = 5;    // holds CNT_W

  localparam logic [FREQ_W-1:0] REST_CODE = 16'd3;

  localparam logic [QT_W-1:0]   QT_RESET   = 16'd1953;
  localparam logic [SONG_W-1:0] SONG_RESET = 9'd184;

  // configuration register index
  localparam logic REG_QUARTER_TICKS = 1'b0;
  localparam logic REG_SONG_LENGTH   = 1'b1;

  // input word kind
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/note_sequencer_sawtooth_tone.sv */
`default_nettype none

// Channel  Direction  tdata fields (low bit up)                      tuser / tlast
// in_      slave      entry_index[7:0] entry_freq[23:8]              tuser: opcode
//                     entry_duration[31:24]                          (0 tick, 1 load)
// out_     master     duty[7:0] note_position[15:8]                  tlast: note_advanced
// cfg_     write      addr 0 quarter_ticks[15:0], addr 1 song_length[8:0]
//
// A load word writes the note table; the block stays ready.
// A sounding tick word keeps in_tready low: table read, setup, then one shared
// restoring divider runs three times (SAMPLE_RATE/freq 14 steps, 127/period 7 steps, counter
// mod period 24 steps, each followed by a hand-off), then finish.
// A rest or 0 Hz entry skips the divider; a note above the sample rate stops after the
// first divide.
// A finished word waits in the output register; the next word is accepted
// meanwhile, and a tick stalls only in its finish state if out_ is still full.
// Reset (rst_n low, synchronous) restores the config defaults and clears the
// counter, note index and handshake state; the note table is not cleared.

module note_sequencer_sawtooth_tone
  import nsst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // entry_index, entry_freq, entry_duration
  input  wire logic        in_tuser,    // opcode

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // duty, note_position
  output logic             out_tlast,   // note_advanced

  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_PER   = 3'd3;   // SAMPLE_RATE / freq
  localparam logic [2:0] S_STP   = 3'd4;   // PWM_HALF / period
  localparam logic [2:0] S_MOD   = 3'd5;   // counter mod period
  localparam logic [2:0] S_FIN   = 3'd6;

  // control state
  logic [2:0]            state_r, state_nxt;
  logic [QT_W-1:0]       quarter_r;
  logic [SONG_W-1:0]     song_r;
  logic [CNT_W-1:0]      tick_r, tick_nxt;
  logic [NOTE_W-1:0]     note_r, note_nxt;
  logic [STEP_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // datapath
  logic [CNT_W-1:0]      dq_r, dq_nxt;       // dividend in, quotient out
  logic [FREQ_W-1:0]     rem_r, rem_nxt;
  logic [FREQ_W-1:0]     div_r, div_nxt;
  logic [SR_W-1:0]       period_r, period_nxt;
  logic [HALF_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]      limit_r, limit_nxt;
  logic [7:0]            duty_r, duty_nxt;
  logic [7:0]            out_duty_r, out_duty_nxt;
  logic [NOTE_W-1:0]     out_pos_r, out_pos_nxt;
  logic                  out_last_r, out_last_nxt;

  // note table
  logic [FREQ_W-1:0]     freq_mem [MAX_NOTES];
  logic [LEN_W-1:0]      len_mem  [MAX_NOTES];
  logic [FREQ_W-1:0]     freq_q;
  logic [LEN_W-1:0]      len_q;

  logic                  in_acc;
  logic                  fin_go;
  logic [FREQ_W:0]       trial;
  logic [FREQ_W:0]       diff;
  logic                  ge;
  logic [15:0]           prod;
  logic [CNT_W-1:0]      tick_inc;
  logic [SONG_W-1:0]     note_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign fin_go     = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_duty_r};
  assign out_tlast  = out_last_r;

  // shared restoring divider step: one quotient bit per cycle
  assign trial = {rem_r, dq_r[CNT_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  // only the low 8 bits of the product survive
  assign prod     = {8'd0, rem_r[7:0]} * {9'd0, step_r};
  assign tick_inc = tick_r + 24'd1;
  assign note_inc = {1'b0, note_r} + 9'd1;

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    note_nxt      = note_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    period_nxt    = period_r;
    step_nxt      = step_r;
    limit_nxt     = limit_r;
    duty_nxt      = duty_r;
    out_duty_nxt  = out_duty_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == OP_TICK) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // table read registers at this edge
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        limit_nxt = CNT_W'({8'd0, len_q} * {8'd0, quarter_r});
        if (freq_q == '0 || freq_q == REST_CODE) begin
          duty_nxt  = 8'd0;
          state_nxt = S_FIN;
        end else begin
          dq_nxt    = CNT_W'(SAMPLE_RATE) << (CNT_W - SR_W);
          rem_nxt   = '0;
          div_nxt   = freq_q;
          dcnt_nxt  = STEP_CNT_W'(SR_W);
          state_nxt = S_PER;
        end
      end
      S_PER, S_STP, S_MOD: begin
        if (dcnt_r != '0) begin
          rem_nxt  = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
          dq_nxt   = {dq_r[CNT_W-2:0], ge};
          dcnt_nxt = dcnt_r - 5'd1;
        end else if (state_r == S_PER) begin
          period_nxt = dq_r[SR_W-1:0];
          if (dq_r[SR_W-1:0] == '0) begin
            duty_nxt  = 8'd0;
            state_nxt = S_FIN;
          end else begin
            dq_nxt    = CNT_W'(PWM_HALF) << (CNT_W - HALF_W);
            rem_nxt   = '0;
            div_nxt   = FREQ_W'(dq_r[SR_W-1:0]);
            dcnt_nxt  = STEP_CNT_W'(HALF_W);
            state_nxt = S_STP;
          end
        end else if (state_r == S_STP) begin
          step_nxt  = dq_r[HALF_W-1:0];
          dq_nxt    = tick_r;
          rem_nxt   = '0;
          div_nxt   = FREQ_W'(period_r);
          dcnt_nxt  = STEP_CNT_W'(CNT_W);
          state_nxt = S_MOD;
        end else begin
          duty_nxt  = prod[7:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = duty_r;
          if (tick_inc == limit_r) begin
            tick_nxt     = '0;
            note_nxt     = (note_inc >= song_r || note_inc >= SONG_W'(MAX_NOTES))
                           ? '0 : note_inc[NOTE_W-1:0];
            out_pos_nxt  = (note_inc >= song_r || note_inc >= SONG_W'(MAX_NOTES))
                           ? '0 : note_inc[NOTE_W-1:0];
            out_last_nxt = 1'b1;
          end else begin
            tick_nxt     = tick_inc;
            out_pos_nxt  = note_r;
            out_last_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quarter_r   <= QT_RESET;
      song_r      <= SONG_RESET;
      tick_r      <= '0;
      note_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      note_r      <= note_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_QUARTER_TICKS: quarter_r <= cfg_wdata;
          REG_SONG_LENGTH:   song_r    <= cfg_wdata[SONG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    period_r   <= period_nxt;
    step_r     <= step_nxt;
    limit_r    <= limit_nxt;
    duty_r     <= duty_nxt;
    out_duty_r <= out_duty_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  // note table: written by load words, read at the current note
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_LOAD) begin
      freq_mem[in_tdata[7:0]] <= in_tdata[23:8];
      len_mem[in_tdata[7:0]]  <= in_tdata[31:24];
    end
    freq_q <= freq_mem[note_r];
    len_q  <= len_mem[note_r];
  end

  // checks
  a_tick_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_TICK) |=> (state_r == S_READ))
    else $error("tick word did not start table read");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_LOAD) |=> (state_r == S_IDLE))
    else $error("load word left idle");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_READ || state_r == S_FIN) |-> (dcnt_r == '0))
    else $error("divider busy outside a divide");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result word not from finish");

  a_advance_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && tick_inc == limit_r) |=> (tick_r == '0 && out_last_r))
    else $error("note end did not clear counter");

endmodule

`default_nettype wire

/* dv/tb_note_sequencer_sawtooth_tone.sv */
`timescale 1ns / 100ps

module tb_note_sequencer_sawtooth_tone;
  import nsst_pkg::*;

  // Idle cycles (nothing accepted anywhere) before the run is declared hung.
  // Worst honest case is the long receiver hold-off plus one tick's divider time.
  localparam int unsigned QUIET_LIMIT = 3000;
  // Roughly one tick's worth of cycles; used to let the block settle.
  localparam int unsigned TICK_CYCLES = 60;
  // Length of the deliberate receiver hold-off.
  localparam int unsigned HOLD_CYCLES = 400;

  // One tone word as it leaves the block.
  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] pos;
    logic       adv;
  } tone_res_t;

  localparam tone_res_t NO_TONE = '0;

  // Directed row: input word plus, for the obvious ones, the tone typed in by hand.
  typedef struct packed {
    logic        op;
    logic [7:0]  idx;
    logic [15:0] freq;
    logic [7:0]  dur;
    logic        typed;
    tone_res_t   tone;
  } stim_row_t;

  // One register setting and the number of words sent under it.
  // walk: march the note index through the whole table, one short note after another.
  typedef struct packed {
    logic [15:0] qt;
    logic [8:0]  song;
    logic [9:0]  words;
    logic        walk;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // entry_index[7:0], entry_freq[23:8], entry_duration[31:24]
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // duty[7:0], note_position[15:8]
  logic        out_tlast;  // note_advanced
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;

  always #1 clk = ~clk;

  note_sequencer_sawtooth_tone dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer shadow: config, tick counter, note index and the note table.
  // m_written tracks which table entries were loaded, so no tick ever plays
  // an entry that holds nothing defined.
  // ---------------------------------------------------------------------------
  logic [15:0] m_qt;
  logic [8:0]  m_song;
  logic [23:0] m_cnt;
  logic [7:0]  m_note;
  logic [15:0] m_freq [0:MAX_NOTES-1];
  logic [7:0]  m_len  [0:MAX_NOTES-1];
  bit          m_written [0:MAX_NOTES-1];

  tone_res_t   pending_tones [$];   // tones owed by the block, oldest first

  int unsigned err_count = 0;
  int unsigned tones_checked = 0;
  int unsigned notes_advanced = 0;
  int unsigned table_wraps = 0;
  int unsigned ticks_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;       // sender offers back to back while set
  bit          hold_req = 1'b0;     // asks the receiver for one long hold-off

  // Sawtooth: period = SAMPLE_RATE / freq, slope = PWM_HALF / period,
  // duty = (count mod period) * slope, low 8 bits. Rest, 0 Hz and
  // freq above the sample rate (period 0) all give silence.
  function automatic logic [7:0] saw_duty(input logic [15:0] freq, input logic [23:0] cnt);
    int unsigned period;
    int unsigned slope;
    int unsigned prod;
    if (freq == REST_CODE || freq == 16'd0) return 8'd0;
    period = SAMPLE_RATE / freq;
    if (period == 0) return 8'd0;
    slope = PWM_HALF / period;
    prod = (cnt % period) * slope;
    return prod[7:0];
  endfunction

  // Apply one accepted word to the shadow; a tick yields one tone word.
  task automatic play_word(input logic op, input logic [7:0] idx, input logic [15:0] freq,
                           input logic [7:0] dur, output bit has_tone, output tone_res_t tone);
    int unsigned limit;
    int unsigned nxt;
    logic [7:0]  cur;
    has_tone = 1'b0;
    tone = NO_TONE;
    if (op == OP_LOAD) begin
      m_freq[idx] = freq;
      m_len[idx] = dur;
      m_written[idx] = 1'b1;
    end else begin
      cur = m_note;
      tone.duty = saw_duty(m_freq[cur], m_cnt);
      m_cnt = m_cnt + 24'd1;              // 24-bit wrap
      limit = m_len[cur];
      limit = limit * m_qt;
      if (m_cnt == limit) begin
        m_cnt = '0;
        nxt = cur + 1;
        // song_length 0 behaves like 1; anything past the table wraps at its end
        if (nxt >= m_song || nxt >= MAX_NOTES) nxt = 0;
        m_note = nxt[7:0];
        tone.adv = 1'b1;
        notes_advanced++;
        if (nxt == 0) table_wraps++;
      end
      tone.pos = m_note;
      has_tone = 1'b1;
    end
  endtask

  // Frequency mix: mostly audible notes with a nonzero slope, plus rest,
  // silence, too-high notes and very low notes (slope 0).
  function automatic logic [15:0] rand_freq();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 16'd0;
      1: return REST_CODE;
      2: return 16'($urandom_range(SAMPLE_RATE + 1, 65535));
      3: return 16'($urandom_range(1, 122));
      4: return 16'hFFFF;
      default: return 16'($urandom_range(123, SAMPLE_RATE));
    endcase
  endfunction

  // Mostly short notes so the index keeps moving; a few long or endless ones.
  function automatic logic [7:0] rand_dur();
    int unsigned r;
    r = $urandom_range(0, 29);
    case (r)
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'($urandom_range(5, 40));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  // Choose the next word from the shadow state. A tick is only issued once the
  // current entry holds a note. A note whose end the counter has already run
  // past (or, on a coin flip, one that never ends) gets its duration rewritten so play moves on.
  task automatic make_word(input bit walk, output logic op, output logic [7:0] idx,
                           output logic [15:0] freq, output logic [7:0] dur);
    logic [7:0]  cur;
    int unsigned song_eff;
    int unsigned lim;
    int unsigned need;
    int unsigned r;
    bit          fix;
    cur = m_note;
    song_eff = (m_song == 0) ? 1 : ((m_song > MAX_NOTES) ? MAX_NOTES : m_song);
    op = OP_LOAD;
    idx = 8'($urandom_range(0, 255));
    freq = rand_freq();
    dur = walk ? 8'd1 : rand_dur();
    lim = m_len[cur];
    lim = lim * m_qt;
    fix = (lim == 0) ? ($urandom_range(0, 1) == 1) : (m_cnt >= lim);
    // long notes get cut short now and then (always while walking)
    if (lim > m_cnt + (walk ? 3 : 64) && $urandom_range(0, walk ? 0 : 7) == 0) fix = 1'b1;
    need = m_cnt / m_qt + 1 + (walk ? 0 : $urandom_range(0, 2));
    if (!m_written[cur]) begin
      idx = cur;
    end else if (fix && need <= 255) begin
      idx = cur;
      dur = need[7:0];
    end else if (walk) begin
      if (!m_written[(cur + 1) % song_eff]) idx = 8'((cur + 1) % song_eff);
      else op = OP_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 68) op = OP_TICK;
      else if (r < 90) idx = 8'((cur + $urandom_range(1, 3)) % song_eff);
    end
  endtask

  // Offer one word, wait for the handshake, update the shadow, then maybe
  // leave a gap. tvalid is only lowered when a gap follows, never toggled
  // within one step.
  task automatic send_word(input logic op, input logic [7:0] idx, input logic [15:0] freq,
                           input logic [7:0] dur, input logic typed, input tone_res_t typed_tone);
    bit          has;
    tone_res_t   t;
    int unsigned gap;
    int unsigned r;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {dur, freq, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    play_word(op, idx, freq, dur, has, t);
    if (has) pending_tones.push_back(typed ? typed_tone : t);
    if (op == OP_LOAD) loads_sent++;
    else ticks_sent++;
    if (steady) begin
      // back to back
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap lengths spread so idle lands on every stage of the divider pass
      r = $urandom_range(0, 9);
      if (r < 4) gap = $urandom_range(1, 3);
      else if (r < 7) gap = $urandom_range(4, 24);
      else if (r < 9) gap = $urandom_range(25, 70);
      else gap = 0;
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every owed tone is out, plus one tick's
  // time in case a load was the last word.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (TICK_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic write_config(input logic [15:0] qt, input logic [8:0] song);
    cfg_we <= 1'b1;
    cfg_addr <= REG_QUARTER_TICKS;
    cfg_wdata <= qt;
    @(posedge clk);
    cfg_addr <= REG_SONG_LENGTH;
    cfg_wdata <= {7'd0, song};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_qt = qt;
    m_song = song;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed words, run with quarter_ticks 2 and song_length 3.
  // Entries 0..2 hold silence, rest and a too-high note; six ticks walk all
  // three and wrap at the song end. Then real tones, a never-ending entry at
  // the top of the table, a 1 Hz note and the lowest note with slope 1.
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [0:24] = '{
    '{OP_LOAD, 8'd0,   16'd0,     8'd1,   1'b0, NO_TONE},
    '{OP_LOAD, 8'd1,   REST_CODE, 8'd1,   1'b0, NO_TONE},
    '{OP_LOAD, 8'd2,   16'hFFFF,  8'd1,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd1, 1'b1}},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd1, 1'b0}},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd2, 1'b1}},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd2, 1'b0}},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd0, 1'b1}},
    '{OP_LOAD, 8'd0,   16'd1000,  8'd255, 1'b0, NO_TONE},
    '{OP_LOAD, 8'd255, 16'd15625, 8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_LOAD, 8'd1,   16'd1,     8'd2,   1'b0, NO_TONE},
    '{OP_LOAD, 8'd2,   16'd123,   8'd1,   1'b0, NO_TONE},
    '{OP_LOAD, 8'd0,   16'd15625, 8'd3,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE},
    '{OP_TICK, 8'd0,   16'd0,     8'd0,   1'b0, NO_TONE}
  };

  // Random phases. The walk runs the index off the end of the table (song
  // length above the table size); the last row's settings are drawn at random.
  phase_t phases [0:6] = '{
    '{16'd1,     9'd300,     10'd540, 1'b1},
    '{16'd1,     9'd256,     10'd50,  1'b0},
    '{16'hFFFF,  9'd1,       10'd35,  1'b0},
    '{16'd1,     9'd0,       10'd35,  1'b0},
    '{QT_RESET,  SONG_RESET, 10'd35,  1'b0},
    '{16'd2,     9'd5,       10'd50,  1'b0},
    '{16'd0,     9'd0,       10'd60,  1'b0}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    phase_t      ph;
    int unsigned p;
    int unsigned i;
    logic        op;
    logic [7:0]  idx;
    logic [7:0]  dur;
    logic [15:0] freq;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_TICK;
    cfg_we = 1'b0;
    cfg_addr = REG_QUARTER_TICKS;
    cfg_wdata = '0;

    // shadow matches the block's reset state; the table starts empty
    m_qt = QT_RESET;
    m_song = SONG_RESET;
    m_cnt = '0;
    m_note = '0;
    for (i = 0; i < MAX_NOTES; i++) m_written[i] = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_config(16'd2, 9'd3);
    for (i = 0; i < 25; i++)
      send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].freq, dir_rows[i].dur,
                dir_rows[i].typed, dir_rows[i].tone);
    settle();

    for (p = 0; p < 7; p++) begin
      ph = phases[p];
      if (p == 6) begin
        ph.qt = 16'($urandom_range(1, 4));
        ph.song = 9'($urandom_range(2, 12));
      end
      write_config(ph.qt, ph.song);
      for (i = 0; i < ph.words; i++) begin
        if (ph.walk && i == 200) begin
          // long receiver hold-off while words keep coming: the output
          // register fills, the next tick stalls and in_tready must drop
          hold_req = 1'b1;
          steady = 1'b1;
        end
        if (ph.walk && i == 240) steady = 1'b0;
        // sender pause mid-phase until the block has drained
        if (ph.walk && i == 400) settle();
        make_word(ph.walk, op, idx, freq, dur);
        send_word(op, idx, freq, dur, 1'b0, NO_TONE);
      end
      settle();
    end

    $display("Sent %0d words (%0d sample ticks, %0d table loads) across %0d register settings.",
             ticks_sent + loads_sent, ticks_sent, loads_sent, settings_used);
    $display("Checked %0d tone words; %0d note changes, %0d wraps to the first note.",
             tones_checked, notes_advanced, table_wraps);
    if (err_count == 0 && pending_tones.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern redrawn at random from four (always ready, coin flip,
  // mostly stalled, alternating); one long hold-off on request.
  // ---------------------------------------------------------------------------
  int unsigned rx_hold = 0;
  int unsigned rx_cyc = 0;
  int unsigned rx_mode = 0;
  bit          hold_seen = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      if (rx_cyc % 40 == 0) rx_mode = $urandom_range(0, 3);
      rx_cyc++;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_cyc % 2 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tone checker: every accepted word against the oldest owed tone.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tone_check
    tone_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tones.size() == 0) begin
        $error("tone word with none owed: duty %0d, note_position %0d, note_advanced %0b",
               out_tdata[7:0], out_tdata[15:8], out_tlast);
        err_count++;
      end else begin
        want = pending_tones.pop_front();
        tones_checked++;
        if (out_tdata[7:0] !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[15:8] !== want.pos) begin
          $error("note_position: expected %0d, got %0d", want.pos, out_tdata[15:8]);
          err_count++;
        end
        if (out_tlast !== want.adv) begin
          $error("note_advanced: expected %0b, got %0b", want.adv, out_tlast);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake or register write counts as progress.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
